// ===== rtl/core/spp_pkg.sv =====
`timescale 1ns / 1ps
package spp_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 8;
  localparam int RADIUS_W  = 31;
  localparam int PENALTY_W = 27;
  localparam int LIMB_W    = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_AVOID_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AVOID_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AVOID_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS  = 2'd3;

  // per-item control that travels beside the wide datapath
  typedef struct packed {
    logic valid;
    logic hit;
  } spp_ctl_t;

endpackage

// ===== rtl/core/spp_mul.sv =====
`timescale 1ns / 1ps
// signed multiply, registered in steps: magnitudes, limb products, sum and sign
module spp_mul import spp_pkg::*; #(
  parameter int AW = COORD_W,
  parameter int BW = COORD_W
) (
  input  logic                     clk,
  input  logic                     ce,
  input  logic signed [AW-1:0]     a,
  input  logic signed [BW-1:0]     b,
  output logic signed [AW+BW-1:0]  p
);

  localparam int NA = (AW + LIMB_W - 1) / LIMB_W;
  localparam int NB = (BW + LIMB_W - 1) / LIMB_W;
  localparam int AP = NA * LIMB_W;
  localparam int BP = NB * LIMB_W;
  localparam int PP = AP + BP;

  logic [AP-1:0]         ma_r;
  logic [BP-1:0]         mb_r;
  logic                  neg_r;
  logic                  neg2_r;
  logic [2*LIMB_W-1:0]   pp_r [NA][NB];
  logic [PP-1:0]         sum;
  logic signed [AW+BW-1:0] p_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      ma_r   <= AP'($unsigned(a[AW-1] ? -a : a));
      mb_r   <= BP'($unsigned(b[BW-1] ? -b : b));
      neg_r  <= a[AW-1] ^ b[BW-1];
      neg2_r <= neg_r;
    end
  end

  for (genvar i = 0; i < NA; i++) begin : g_row
    for (genvar j = 0; j < NB; j++) begin : g_col
      always_ff @(posedge clk) begin
        if (ce) begin
          pp_r[i][j] <= (2*LIMB_W)'(ma_r[i*LIMB_W +: LIMB_W]) *
                        (2*LIMB_W)'(mb_r[j*LIMB_W +: LIMB_W]);
        end
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum = sum + (PP'(pp_r[i][j]) << (LIMB_W * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      p_r <= neg2_r ? -((AW+BW)'(sum)) : (AW+BW)'(sum);
    end
  end

  assign p = p_r;

endmodule

// ===== rtl/core/spp_root.sv =====
`timescale 1ns / 1ps
// ceil(sqrt(ceil(num / den))): restoring divider, one quotient bit per stage,
// then restoring square root, one root bit per stage
module spp_root import spp_pkg::*; #(
  parameter int NW = 4 * COORD_W + 15,
  parameter int DW = 2 * COORD_W + 4,
  parameter int QW = 2 * RADIUS_W + 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              ce,
  input  spp_ctl_t          in_ctl,
  input  logic [NW-1:0]     in_num,
  input  logic [DW-1:0]     in_den,
  output spp_ctl_t          out_ctl,
  output logic [(QW+2)/2:0] out_root
);

  localparam int SQ = (QW + 2) / 2;
  localparam int MP = 2 * SQ;

  spp_ctl_t      dv_ctl [QW+1];
  logic [DW-1:0] dv_rem [QW+1];
  logic [QW-1:0] dv_n   [QW+1];
  logic [DW-1:0] dv_dd  [QW+1];

  spp_ctl_t      sq_ctl  [SQ+1];
  logic [MP-1:0] sq_m    [SQ+1];
  logic [SQ-1:0] sq_root [SQ+1];
  logic [SQ+1:0] sq_rem  [SQ+1];

  spp_ctl_t      out_ctl_r;
  logic [SQ:0]   out_root_r;

  // quotient stays within QW bits whenever the item is inside the radius
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_ctl[0] <= '0;
    end else if (ce) begin
      dv_ctl[0] <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      dv_rem[0] <= DW'(in_num >> QW);
      dv_n[0]   <= QW'(in_num);
      dv_dd[0]  <= in_den;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [DW:0] t;
    logic        ge;
    assign t  = {dv_rem[k], dv_n[k][QW-1]};
    assign ge = t >= {1'b0, dv_dd[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_ctl[k+1] <= '0;
      end else if (ce) begin
        dv_ctl[k+1] <= dv_ctl[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        dv_rem[k+1] <= ge ? DW'(t - {1'b0, dv_dd[k]}) : DW'(t);
        dv_n[k+1]   <= {dv_n[k][QW-2:0], ge};
        dv_dd[k+1]  <= dv_dd[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_ctl[0] <= '0;
    end else if (ce) begin
      sq_ctl[0] <= dv_ctl[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sq_m[0]    <= MP'(dv_n[QW]) + MP'(dv_rem[QW] != '0);
      sq_root[0] <= '0;
      sq_rem[0]  <= '0;
    end
  end

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    logic [SQ+3:0] t;
    logic [SQ+3:0] trial;
    logic          ge;
    assign t     = {sq_rem[k], sq_m[k][MP-1 -: 2]};
    assign trial = (SQ+4)'({sq_root[k], 2'b01});
    assign ge    = t >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_ctl[k+1] <= '0;
      end else if (ce) begin
        sq_ctl[k+1] <= sq_ctl[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        sq_rem[k+1]  <= ge ? (SQ+2)'(t - trial) : (SQ+2)'(t);
        sq_root[k+1] <= {sq_root[k][SQ-2:0], ge};
        sq_m[k+1]    <= {sq_m[k][MP-3:0], 2'b00};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_ctl_r <= '0;
    end else if (ce) begin
      out_ctl_r <= sq_ctl[SQ];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_root_r <= (SQ+1)'(sq_root[SQ]) + (SQ+1)'(sq_rem[SQ] != '0);
    end
  end

  assign out_ctl  = out_ctl_r;
  assign out_root = out_root_r;

endmodule

// ===== rtl/core/segment_proximity_penalty_core.sv =====
`timescale 1ns / 1ps
// Pipeline: stages S0 to S11, then (2*RADIUS_W+7) divider stages and (RADIUS_W+4) root
//   stages in spp_root, then the output register.
// Throughput: one transaction per cycle; the whole pipeline advances together and
//   holds when the output register is full and not taken.
// Reset: rst_n synchronous, active low; clears valid bits, the avoid registers and the radius.
module segment_proximity_penalty_core import spp_pkg::*; #(
  parameter int COORD_WIDTH   = COORD_W,
  parameter int FRACTION_BITS = FRAC_BITS
) (
  input  logic clk,
  input  logic rst_n,
  // segment input
  input  logic in_tvalid,
  output logic in_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  // penalty result
  output logic out_tvalid,
  input  logic out_tready,
  // penalty
  output logic [((PENALTY_W+7)/8)*8-1:0] out_tdata,
  // register writes
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [((COORD_WIDTH > RADIUS_W) ? COORD_WIDTH : RADIUS_W)-1:0] cfg_data
);

  localparam int CW   = COORD_WIDTH;
  localparam int FB   = FRACTION_BITS;
  localparam int TOL  = ((1 << FB) + 5) / 10;   // 0.1 in LSB, halves up
  localparam int D    = CW + 1;                 // coordinate difference
  localparam int U    = CW + 2;                 // widened box edge
  localparam int P1   = 2 * D;                  // square of a difference
  localparam int SW   = P1 + 2;                 // sum of three squares
  localparam int RS   = RADIUS_W + 1;
  localparam int R2W  = 2 * RS;
  localparam int DN   = D + SW;
  localparam int UD   = U + SW;
  localparam int QQ   = 2 * SW;
  localparam int R2D  = R2W + SW;
  localparam int CMPW = ((QQ > R2D) ? QQ : R2D) + 1;
  localparam int NW   = QQ + 7;                 // 100 * q
  localparam int QTW  = 2 * RADIUS_W + 7;       // quotient bits
  localparam int SQ   = (QTW + 2) / 2;          // root bits
  localparam int XW   = ((RADIUS_W + 4 > SQ + 1) ? RADIUS_W + 4 : SQ + 1) + 1;
  localparam int OTW  = ((PENALTY_W + 7) / 8) * 8;
  localparam int ML   = 3;                      // multiplier latency

  localparam logic signed [U-1:0] TOLU = U'(TOL);

  // ---------------------------------------------------------------------------
  // Configuration. The user must write only while the pipeline is empty; the block
  // itself does not enforce this. The registers are read directly where they are used.
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0]   avoid_r [3];
  logic [RADIUS_W-1:0]    radius_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avoid_r[0] <= '0;
      avoid_r[1] <= '0;
      avoid_r[2] <= '0;
      radius_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_AVOID_X: avoid_r[0] <= cfg_data[CW-1:0];
        CFG_AVOID_Y: avoid_r[1] <= cfg_data[CW-1:0];
        CFG_AVOID_Z: avoid_r[2] <= cfg_data[CW-1:0];
        CFG_RADIUS:  radius_r   <= cfg_data[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  // Global advance: every stage moves when the output register can take data.
  logic ce;
  logic out_valid_r;
  logic [PENALTY_W-1:0] out_pen_r;

  assign ce        = !out_valid_r || out_tready;
  assign in_tready = ce;

  // ---------------------------------------------------------------------------
  // S0: capture the segment
  // ---------------------------------------------------------------------------
  logic                 v0_r;
  logic signed [CW-1:0] start_r [3];
  logic signed [CW-1:0] end_r   [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (ce) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int a = 0; a < 3; a++) begin
        start_r[a] <= in_tdata[a*CW +: CW];
        end_r[a]   <= in_tdata[(a+3)*CW +: CW];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // S1: direction D = E - S, W = A - S, A - E, and the widened box edges
  // relative to S (max(S,E) + tol - S, min(S,E) - tol - S).
  // ---------------------------------------------------------------------------
  logic                v1_r;
  logic signed [D-1:0] d1_nxt  [3];
  logic signed [U-1:0] uh1_nxt [3];
  logic signed [U-1:0] ul1_nxt [3];
  logic signed [D-1:0] d1_r    [3];
  logic signed [D-1:0] w1_r    [3];
  logic signed [D-1:0] e1_r    [3];
  logic signed [U-1:0] uh1_r   [3];
  logic signed [U-1:0] ul1_r   [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      d1_nxt[a]  = D'(end_r[a]) - D'(start_r[a]);
      uh1_nxt[a] = (d1_nxt[a] > 0) ? U'(d1_nxt[a]) + TOLU : TOLU;
      ul1_nxt[a] = (d1_nxt[a] < 0) ? U'(d1_nxt[a]) - TOLU : -TOLU;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (ce) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int a = 0; a < 3; a++) begin
        d1_r[a]  <= d1_nxt[a];
        w1_r[a]  <= D'(avoid_r[a]) - D'(start_r[a]);
        e1_r[a]  <= D'(avoid_r[a]) - D'(end_r[a]);
        uh1_r[a] <= uh1_nxt[a];
        ul1_r[a] <= ul1_nxt[a];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // First product group: D*D, W*D, W*W, (A-E)^2 per axis, and r^2.
  // ---------------------------------------------------------------------------
  logic signed [D-1:0]   g1a [12];
  logic signed [D-1:0]   g1b [12];
  logic signed [P1-1:0]  g1p [12];
  logic signed [R2W-1:0] r2p;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      g1a[a]   = d1_r[a];  g1b[a]   = d1_r[a];
      g1a[3+a] = w1_r[a];  g1b[3+a] = d1_r[a];
      g1a[6+a] = w1_r[a];  g1b[6+a] = w1_r[a];
      g1a[9+a] = e1_r[a];  g1b[9+a] = e1_r[a];
    end
  end

  for (genvar i = 0; i < 12; i++) begin : g_mul1
    spp_mul #(.AW(D), .BW(D)) u_mul (
      .clk (clk),
      .ce  (ce),
      .a   (g1a[i]),
      .b   (g1b[i]),
      .p   (g1p[i])
    );
  end

  spp_mul #(.AW(RS), .BW(RS)) u_mul_r2 (
    .clk (clk),
    .ce  (ce),
    .a   ($signed({1'b0, radius_r})),
    .b   ($signed({1'b0, radius_r})),
    .p   (r2p)
  );

  // side data riding along with the first product group
  logic [ML-1:0]       vd1_r;
  logic signed [D-1:0] dl_d_r  [ML][3];
  logic signed [U-1:0] dl_uh_r [ML][3];
  logic signed [U-1:0] dl_ul_r [ML][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd1_r <= '0;
    end else if (ce) begin
      vd1_r <= {vd1_r[ML-2:0], v1_r};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      dl_d_r[0]  <= d1_r;
      dl_uh_r[0] <= uh1_r;
      dl_ul_r[0] <= ul1_r;
      for (int k = 1; k < ML; k++) begin
        dl_d_r[k]  <= dl_d_r[k-1];
        dl_uh_r[k] <= dl_uh_r[k-1];
        dl_ul_r[k] <= dl_ul_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // S5: den = D.D, num = W.D, w2 = W.W, qe = |A-E|^2
  // ---------------------------------------------------------------------------
  logic                  v5_r;
  logic signed [SW-1:0]  den5_r, num5_r, w25_r, qe5_r;
  logic signed [R2W-1:0] r25_r;
  logic signed [D-1:0]   d5_r  [3];
  logic signed [U-1:0]   uh5_r [3];
  logic signed [U-1:0]   ul5_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (ce) begin
      v5_r <= vd1_r[ML-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      den5_r <= SW'(g1p[0]) + SW'(g1p[1]) + SW'(g1p[2]);
      num5_r <= SW'(g1p[3]) + SW'(g1p[4]) + SW'(g1p[5]);
      w25_r  <= SW'(g1p[6]) + SW'(g1p[7]) + SW'(g1p[8]);
      qe5_r  <= SW'(g1p[9]) + SW'(g1p[10]) + SW'(g1p[11]);
      r25_r  <= r2p;
      d5_r   <= dl_d_r[ML-1];
      uh5_r  <= dl_uh_r[ML-1];
      ul5_r  <= dl_ul_r[ML-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Second product group. The box test compares d*num against edge*den on
  // each axis, so no division is needed. q = den*w2 - num^2 is the squared
  // distance to the foot, scaled by den.
  // ---------------------------------------------------------------------------
  logic signed [DN-1:0]  pdn [3];
  logic signed [UD-1:0]  puh [3];
  logic signed [UD-1:0]  pul [3];
  logic signed [QQ-1:0]  pdw2, pnn;
  logic signed [R2D-1:0] pr2d;

  for (genvar a = 0; a < 3; a++) begin : g_mul2
    spp_mul #(.AW(D), .BW(SW)) u_mul_dn (
      .clk (clk), .ce (ce), .a (d5_r[a]), .b (num5_r), .p (pdn[a])
    );
    spp_mul #(.AW(U), .BW(SW)) u_mul_uh (
      .clk (clk), .ce (ce), .a (uh5_r[a]), .b (den5_r), .p (puh[a])
    );
    spp_mul #(.AW(U), .BW(SW)) u_mul_ul (
      .clk (clk), .ce (ce), .a (ul5_r[a]), .b (den5_r), .p (pul[a])
    );
  end

  spp_mul #(.AW(SW), .BW(SW)) u_mul_dw2 (
    .clk (clk), .ce (ce), .a (den5_r), .b (w25_r), .p (pdw2)
  );

  spp_mul #(.AW(SW), .BW(SW)) u_mul_nn (
    .clk (clk), .ce (ce), .a (num5_r), .b (num5_r), .p (pnn)
  );

  spp_mul #(.AW(R2W), .BW(SW)) u_mul_r2d (
    .clk (clk), .ce (ce), .a (r25_r), .b (den5_r), .p (pr2d)
  );

  logic [ML-1:0]         vd5_r;
  logic signed [SW-1:0]  dl_den_r [ML];
  logic signed [SW-1:0]  dl_qe_r  [ML];
  logic signed [R2W-1:0] dl_r2_r  [ML];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd5_r <= '0;
    end else if (ce) begin
      vd5_r <= {vd5_r[ML-2:0], v5_r};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      dl_den_r[0] <= den5_r;
      dl_qe_r[0]  <= qe5_r;
      dl_r2_r[0]  <= r25_r;
      for (int k = 1; k < ML; k++) begin
        dl_den_r[k] <= dl_den_r[k-1];
        dl_qe_r[k]  <= dl_qe_r[k-1];
        dl_r2_r[k]  <= dl_r2_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // S9: box test; the foot is used only for a nonzero segment inside the box
  // ---------------------------------------------------------------------------
  logic                  outside;
  logic                  v9_r;
  logic                  proj9_r;
  logic signed [QQ-1:0]  qp9_r;
  logic signed [SW-1:0]  qe9_r, den9_r;
  logic signed [R2W-1:0] r29_r;
  logic signed [R2D-1:0] r2d9_r;

  always_comb begin
    outside = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if ((UD'(pdn[a]) > puh[a]) || (UD'(pdn[a]) < pul[a])) begin
        outside = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r <= 1'b0;
    end else if (ce) begin
      v9_r <= vd5_r[ML-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      proj9_r <= (dl_den_r[ML-1] != '0) && !outside;
      qp9_r   <= pdw2 - pnn;
      qe9_r   <= dl_qe_r[ML-1];
      den9_r  <= dl_den_r[ML-1];
      r29_r   <= dl_r2_r[ML-1];
      r2d9_r  <= pr2d;
    end
  end

  // ---------------------------------------------------------------------------
  // S10: pick q / dd and test q < r^2 * dd
  // ---------------------------------------------------------------------------
  logic signed [QQ-1:0]   q10_nxt;
  logic signed [CMPW-1:0] thr10;
  logic                   v10_r;
  logic                   in10_r;
  logic [QQ-1:0]          q10_r;
  logic [SW-1:0]          dd10_r;

  assign q10_nxt = proj9_r ? qp9_r : QQ'(qe9_r);
  assign thr10   = proj9_r ? CMPW'(r2d9_r) : CMPW'(r29_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v10_r <= 1'b0;
    end else if (ce) begin
      v10_r <= v9_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      q10_r  <= q10_nxt;
      dd10_r <= proj9_r ? den9_r : SW'(1);
      in10_r <= CMPW'(q10_nxt) < thr10;
    end
  end

  // ---------------------------------------------------------------------------
  // S11: 100 * q for the ten-times distance
  // ---------------------------------------------------------------------------
  spp_ctl_t      ctl11_r;
  logic [NW-1:0] n11_r;
  logic [SW-1:0] dd11_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl11_r <= '0;
    end else if (ce) begin
      ctl11_r <= '{valid: v10_r, hit: in10_r};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      n11_r  <= (NW'(q10_r) << 6) + (NW'(q10_r) << 5) + (NW'(q10_r) << 2);
      dd11_r <= dd10_r;
    end
  end

  // ---------------------------------------------------------------------------
  // c = ceil(10 * distance) in LSB, so that t >= 10*d exactly when t >= c
  // ---------------------------------------------------------------------------
  spp_ctl_t    rt_ctl;
  logic [SQ:0] rt_root;

  spp_root #(.NW(NW), .DW(SW), .QW(QTW)) u_root (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce       (ce),
    .in_ctl   (ctl11_r),
    .in_num   (n11_r),
    .in_den   (dd11_r),
    .out_ctl  (rt_ctl),
    .out_root (rt_root)
  );

  // ---------------------------------------------------------------------------
  // Output: floor((10r - c) / 2^F); c <= 10r whenever the point is inside
  // ---------------------------------------------------------------------------
  logic [XW-1:0]        r10;
  logic [XW-1:0]        diff;
  logic [PENALTY_W-1:0] pen_nxt;

  assign r10     = (XW'(radius_r) << 3) + (XW'(radius_r) << 1);
  assign diff    = r10 - XW'(rt_root);
  assign pen_nxt = (rt_ctl.hit && (radius_r != '0)) ? PENALTY_W'(diff >> FB) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ce) begin
      out_valid_r <= rt_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_pen_r <= pen_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OTW'(out_pen_r);

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import spp_pkg::*;

  // wide signed math for the exact distance test; 256 bits covers every product
  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic signed [31:0] sx, sy, sz, ex, ey, ez;
  } segment_t;

  localparam int  LATENCY   = 119;
  localparam int  TOL_LSB   = ((1 << FRAC_BITS) + 5) / 10;  // 0.1 widening of the box
  localparam int  WDOG_MAX  = 4000;
  localparam int  HOLD_LEN  = 400;   // long receiver hold-off
  localparam int  HOLD_AT   = 150;   // after this many results

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [191:0] in_tdata;   // start_x, start_y, start_z, end_x, end_y, end_z
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;   // penalty in [26:0], zero fill above
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  segment_proximity_penalty_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // shadow copy of the avoid registers, updated on each cfg transaction
  logic signed [31:0] av_x, av_y, av_z;
  logic [30:0]        av_r;

  segment_t        seg_pending[$];
  logic [26:0]     penalty_due[$];
  int              errors;
  int              n_in, n_out, n_cfg, n_hit;
  int              idle_cycles;

  function automatic logic axis_outside(wide_t s, wide_t e, wide_t d, wide_t num, wide_t den);
    wide_t hi, lo, a;
    hi = (s > e) ? s : e;
    lo = (s < e) ? s : e;
    a  = d * num;
    if (a > (hi + TOL_LSB - s) * den) return 1'b1;
    return a < (lo - TOL_LSB - s) * den;
  endfunction

  // Expected penalty for one segment against the current avoid point.
  function automatic logic [26:0] calc_penalty(segment_t g);
    wide_t sx, sy, sz, ex, ey, ez, ax, ay, az, r;
    wide_t dx, dy, dz, wx, wy, wz, den, num, q, dd, w2, hq, t;
    logic  outside;
    longint lo, hi, mid;
    if (av_r == 0) return '0;
    sx = g.sx; sy = g.sy; sz = g.sz;
    ex = g.ex; ey = g.ey; ez = g.ez;
    ax = av_x; ay = av_y; az = av_z;
    r  = {225'd0, av_r};
    dx = ex - sx; dy = ey - sy; dz = ez - sz;
    wx = ax - sx; wy = ay - sy; wz = az - sz;
    den = dx*dx + dy*dy + dz*dz;
    // end point unless the foot falls inside the widened box
    q  = (ax-ex)*(ax-ex) + (ay-ey)*(ay-ey) + (az-ez)*(az-ez);
    dd = 1;
    if (den > 0) begin
      num = wx*dx + wy*dy + wz*dz;
      outside = axis_outside(sx, ex, dx, num, den) || axis_outside(sy, ey, dy, num, den)
             || axis_outside(sz, ez, dz, num, den);
      if (!outside) begin
        w2 = wx*wx + wy*wy + wz*wz;
        q  = den*w2 - num*num;
        dd = den;
      end
    end
    if (q >= r*r*dd) return '0;
    // largest k with 10*d <= 10*r - k*2^F
    hq = q * 100;
    lo = 0;
    hi = (longint'(av_r) * 10) >> FRAC_BITS;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      t = longint'(av_r) * 10 - (mid << FRAC_BITS);
      if (hq <= t*t*dd) lo = mid;
      else hi = mid - 1;
    end
    return lo[26:0];
  endfunction

  // ---------------- driver: one transaction per queued segment ----------------
  segment_t cur_seg;
  int       in_gap;
  logic     in_burst;

  always @(posedge clk) begin
    logic nv;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_gap    = 0;
      in_burst  = 1'b0;
    end else begin
      nv = in_tvalid;
      if (in_tvalid && in_tready) begin
        penalty_due.push_back(calc_penalty(cur_seg));
        n_in++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (seg_pending.size() > 0) begin
          cur_seg = seg_pending.pop_front();
          in_tdata <= {cur_seg.ez, cur_seg.ey, cur_seg.ex, cur_seg.sz, cur_seg.sy, cur_seg.sx};
          nv = 1'b1;
          if ($urandom_range(0, 19) == 0) in_burst = !in_burst;
          in_gap = in_burst ? 0 : $urandom_range(0, 9);
        end
      end
      in_tvalid <= nv;
    end
  end

  // ---------------- monitor: receiver stalls and result check ----------------
  int   out_gap;
  int   hold_cnt;
  logic hold_done;

  always @(posedge clk) begin
    logic [26:0] exp_p;
    logic        nr;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap    = 0;
      hold_cnt   = 0;
      hold_done  = 1'b0;
    end else begin
      nr = out_tready;
      if (out_tvalid && out_tready) begin
        n_out++;
        if (penalty_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d", $time, out_tdata);
          errors++;
        end else begin
          exp_p = penalty_due.pop_front();
          if (exp_p != 0) n_hit++;
          if (out_tdata !== {5'd0, exp_p}) begin
            $display("%0t: penalty expected %0d, actual %0d", $time, exp_p, out_tdata);
            errors++;
          end
        end
        nr = 1'b0;
        out_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
        // one long hold-off so the pipeline backs up to the input
        if (!hold_done && n_out >= HOLD_AT) begin
          hold_done = 1'b1;
          hold_cnt  = HOLD_LEN;
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        nr = 1'b0;
      end else if (!nr) begin
        if (out_gap > 0) out_gap--;
        else nr = 1'b1;
      end
      out_tready <= nr;
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WDOG_MAX) begin
        $display("segment_proximity_penalty_core: mismatch");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_AVOID_X: av_x = val;
      CFG_AVOID_Y: av_y = val;
      CFG_AVOID_Z: av_z = val;
      CFG_RADIUS:  av_r = val[30:0];
      default: ;
    endcase
    n_cfg++;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_avoid(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [30:0] r);
    write_reg(CFG_AVOID_X, x);
    write_reg(CFG_AVOID_Y, y);
    write_reg(CFG_AVOID_Z, z);
    write_reg(CFG_RADIUS, {1'b0, r});
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (seg_pending.size() != 0 || in_tvalid || penalty_due.size() != 0);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic signed [31:0] near(logic signed [31:0] c, int span);
    return c + $signed($urandom_range(0, 2*span)) - span;
  endfunction

  task automatic add_seg(logic signed [31:0] a, logic signed [31:0] b, logic signed [31:0] c,
                         logic signed [31:0] d, logic signed [31:0] e, logic signed [31:0] f);
    segment_t g;
    g.sx = a; g.sy = b; g.sz = c; g.ex = d; g.ey = e; g.ez = f;
    seg_pending.push_back(g);
  endtask

  // random segments: mostly around the avoid point, some anywhere, some zero length
  task automatic add_random(int n);
    segment_t g;
    int span, k;
    span = (av_r == 0) ? 4096 : ((av_r > 31'h1FFF_FFFF) ? 32'h3FFF_FFFF : 2 * int'(av_r));
    repeat (n) begin
      k = $urandom_range(0, 9);
      if (k < 2) begin
        g.sx = $urandom; g.sy = $urandom; g.sz = $urandom;
        g.ex = $urandom; g.ey = $urandom; g.ez = $urandom;
      end else begin
        g.sx = near(av_x, span); g.sy = near(av_y, span); g.sz = near(av_z, span);
        g.ex = near(av_x, span); g.ey = near(av_y, span); g.ez = near(av_z, span);
        if (k == 2) begin
          g.ex = g.sx; g.ey = g.sy; g.ez = g.sz;
        end
      end
      seg_pending.push_back(g);
    end
  endtask

  localparam logic signed [31:0] MAXC = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MINC = 32'sh8000_0000;

  initial begin
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    av_x = 0; av_y = 0; av_z = 0; av_r = 0;
    errors = 0; n_in = 0; n_out = 0; n_cfg = 0; n_hit = 0;
    idle_cycles = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset config: radius zero, penalty disabled
    add_seg(0, 0, 0, 0, 0, 0);
    add_seg(MAXC, MAXC, MAXC, MINC, MINC, MINC);
    add_random(20);
    wait_drained();

    // radius 10.0 (2560 LSB) around the origin: directed geometry
    set_avoid(0, 0, 0, 31'd10 << 8);
    add_seg(0, 0, 0, 0, 0, 0);                   // zero length on the avoid point
    add_seg(100, 100, 100, 100, 100, 100);       // zero length nearby
    add_seg(-2560, 0, 0, 2560, 0, 0);            // passes through the point
    add_seg(-2560, 512, 0, 2560, 512, 0);        // foot inside the box
    add_seg(26, 256, 0, 512, 256, 0);            // foot right at the tolerance edge
    add_seg(27, 256, 0, 512, 256, 0);            // foot just past the tolerance
    add_seg(-512, 256, 0, -26, 256, 0);
    add_seg(-512, 256, 0, -27, 256, 0);
    add_seg(2559, 0, 0, 2559, 0, 0);             // barely inside the radius
    add_seg(2560, 0, 0, 2560, 0, 0);             // exactly on the radius
    add_seg(MAXC, MAXC, MAXC, MINC, MINC, MINC); // long diagonal through origin
    add_seg(MINC, MINC, MINC, MAXC, MAXC, MAXC);
    add_seg(MAXC, 0, 0, MINC, 0, 0);
    add_random(60);
    wait_drained();

    // extreme avoid point and maximum radius
    set_avoid(MAXC, MINC, 0, 31'h7FFF_FFFF);
    add_seg(MAXC, MINC, 0, MAXC, MINC, 0);
    add_seg(MINC, MAXC, MAXC, MAXC, MINC, MINC);
    add_seg(MAXC, MAXC, MAXC, MINC, MINC, MINC);
    add_seg(MINC, MINC, MINC, MINC, MINC, MINC);
    add_random(60);
    wait_drained();

    set_avoid(MINC, MAXC, MINC, 31'd1);
    add_seg(MINC, MAXC, MINC, MINC, MAXC, MINC);
    add_random(40);
    wait_drained();

    repeat (4) begin
      set_avoid(near(0, 1 << 20), near(0, 1 << 20), near(0, 1 << 20),
                31'($urandom_range(1, 1 << 16)));
      add_random(55);
      wait_drained();
    end

    $display("covered %0d segments, %0d results (%0d nonzero penalties), %0d register writes",
             n_in, n_out, n_hit, n_cfg);
    $display("settings: disabled, origin, extreme corners, minimum radius, random points");
    if (errors == 0) begin
      $display("segment_proximity_penalty_core: match");
    end else begin
      $display("segment_proximity_penalty_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/spp_pkg.sv
rtl/core/spp_mul.sv
rtl/core/spp_root.sv
rtl/core/segment_proximity_penalty_core.sv
dv/testbench.sv
